// ===== hw/rtl/sgrm_pkg.sv =====
// sgrm_pkg: shared types and constants of the sequence gap / reboot monitor.
// No dependencies.
package sgrm_pkg;

	localparam int SEQ_W    = 8;
	localparam int SEARCH_W = 16;
	localparam int TOTAL_W  = 32;

	localparam logic [SEQ_W-1:0] SEQ_RESTART    = 8'h00;
	localparam logic [SEQ_W-1:0] SEQ_WRAP_LAST  = 8'hFF;
	localparam logic [SEQ_W-1:0] SEQ_WRAP_FIRST = 8'h01;
	localparam logic [SEQ_W-1:0] SEQ_STEP       = 8'h01;
	localparam logic [SEQ_W-1:0] SEQ_BACK_SKIP  = 8'h02;

	typedef struct packed {
		logic [SEQ_W-1:0]    seq;
		logic [SEARCH_W-1:0] search;
	} item_t;

	typedef struct packed {
		logic               reboot;
		logic [SEQ_W-1:0]   lost;
		logic               dup;
		logic [TOTAL_W-1:0] reboot_total;
		logic [TOTAL_W-1:0] received_total;
		logic [TOTAL_W-1:0] lost_total;
	} result_t;

endpackage

// ===== hw/rtl/sgrm_core.sv =====
// sgrm_core: detector and loss-counter state with the per-transaction update.
// Depends on sgrm_pkg.
module sgrm_core import sgrm_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	output result_t res
);

	logic [SEQ_W-1:0]       prev_seq_reboot_q;
	logic [SEARCH_W-1:0]    prev_search_q;
	logic [SEQ_W-1:0]       prev_seq_loss_q;
	logic                   first_taken_q;
	logic [COUNT_WIDTH-1:0] reboot_cnt_q;
	logic [COUNT_WIDTH-1:0] received_cnt_q;
	logic [COUNT_WIDTH-1:0] lost_cnt_q;

	logic                   reboot;
	logic                   dup;
	logic                   gap;
	logic [SEQ_W-1:0]       lost;
	logic                   latch_loss;
	logic [COUNT_WIDTH:0]   reboot_sum;
	logic [COUNT_WIDTH:0]   received_sum;
	logic [COUNT_WIDTH:0]   lost_sum;
	logic [COUNT_WIDTH-1:0] reboot_nxt;
	logic [COUNT_WIDTH-1:0] received_nxt;
	logic [COUNT_WIDTH-1:0] lost_nxt;

	always_comb begin
		if (item.seq == SEQ_RESTART) begin
			reboot = 1'b1;
		end else if (item.seq == SEQ_WRAP_FIRST && prev_seq_reboot_q == SEQ_WRAP_LAST) begin
			reboot = 1'b0;
		end else begin
			reboot = (item.seq < prev_seq_reboot_q) && (item.search < prev_search_q);
		end
	end

	always_comb begin
		dup        = 1'b0;
		gap        = 1'b0;
		lost       = '0;
		latch_loss = 1'b1;
		if (!first_taken_q || reboot) begin
			latch_loss = 1'b1;
		end else if (item.seq == SEQ_WRAP_FIRST && prev_seq_loss_q == SEQ_WRAP_LAST) begin
			latch_loss = 1'b1;
		end else if (prev_seq_loss_q != SEQ_WRAP_LAST
				&& item.seq == prev_seq_loss_q + SEQ_STEP) begin
			latch_loss = 1'b1;
		end else if (item.seq == prev_seq_loss_q) begin
			dup        = 1'b1;
			latch_loss = 1'b0;
		end else begin
			gap = 1'b1;
			if (item.seq > prev_seq_loss_q) begin
				lost = item.seq - prev_seq_loss_q - SEQ_STEP;
			end else begin
				lost = item.seq - prev_seq_loss_q - SEQ_BACK_SKIP;
			end
		end
	end

	// saturating counters: carry out of the add means stick at all ones
	assign reboot_sum   = {1'b0, reboot_cnt_q} + (COUNT_WIDTH+1)'(reboot);
	assign received_sum = {1'b0, received_cnt_q} + (COUNT_WIDTH+1)'(1'b1);
	assign lost_sum     = {1'b0, lost_cnt_q} + (COUNT_WIDTH+1)'(gap ? lost : '0);

	assign reboot_nxt   = reboot_sum[COUNT_WIDTH] ? '1 : reboot_sum[COUNT_WIDTH-1:0];
	assign received_nxt = received_sum[COUNT_WIDTH] ? '1 : received_sum[COUNT_WIDTH-1:0];
	assign lost_nxt     = lost_sum[COUNT_WIDTH] ? '1 : lost_sum[COUNT_WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_seq_reboot_q <= '0;
			prev_search_q     <= '0;
			prev_seq_loss_q   <= '0;
			first_taken_q     <= 1'b0;
			reboot_cnt_q      <= '0;
			received_cnt_q    <= '0;
			lost_cnt_q        <= '0;
		end else if (fire) begin
			prev_seq_reboot_q <= item.seq;
			prev_search_q     <= item.search;
			first_taken_q     <= 1'b1;
			reboot_cnt_q      <= reboot_nxt;
			received_cnt_q    <= received_nxt;
			lost_cnt_q        <= lost_nxt;
			if (latch_loss) begin
				prev_seq_loss_q <= item.seq;
			end
		end
	end

	assign res.reboot         = reboot;
	assign res.lost           = lost;
	assign res.dup            = dup;
	assign res.reboot_total   = TOTAL_W'(reboot_nxt);
	assign res.received_total = TOTAL_W'(received_nxt);
	assign res.lost_total     = TOTAL_W'(lost_nxt);

endmodule

// ===== hw/rtl/sequence_gap_reboot_monitor.sv =====
// Channel  | valid / stall         | payload
// pkt      | pkt_valid / pkt_stall | sequence_number, search_count
// res      | res_valid / res_stall | reboot_seen, lost_now, duplicate_seen, *_total
//
// One packet per cycle while res_stall is low, via input register then result register.
// The detector and counter state update as a packet moves from the input register
// into the result register. Reset clears core state, counters, valid bits; no sweep.
// A stalled result holds; pkt_stall rises only when both registers are full.
// Depends on sgrm_pkg and sgrm_core.
module sequence_gap_reboot_monitor import sgrm_pkg::*; #(
	parameter int COUNT_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pkt_valid,
	output logic                pkt_stall,
	input  logic [SEQ_W-1:0]    sequence_number,
	input  logic [SEARCH_W-1:0] search_count,
	output logic                res_valid,
	input  logic                res_stall,
	output logic                reboot_seen,
	output logic [SEQ_W-1:0]    lost_now,
	output logic                duplicate_seen,
	output logic [TOTAL_W-1:0]  reboot_total,
	output logic [TOTAL_W-1:0]  received_total,
	output logic [TOTAL_W-1:0]  lost_total
);

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_comb;
	logic    s2_free;
	logic    fire;

	assign s2_free   = !valid_s2 || !res_stall;
	assign fire      = valid_s1 && s2_free;
	assign pkt_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!pkt_stall) begin
			valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && !pkt_stall) begin
			item_s1.seq    <= sequence_number;
			item_s1.search <= search_count;
		end
	end

	sgrm_core #(
		.COUNT_WIDTH(COUNT_WIDTH)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.fire  (fire),
		.item  (item_s1),
		.res   (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid      = valid_s2;
	assign reboot_seen    = res_s2.reboot;
	assign lost_now       = res_s2.lost;
	assign duplicate_seen = res_s2.dup;
	assign reboot_total   = res_s2.reboot_total;
	assign received_total = res_s2.received_total;
	assign lost_total     = res_s2.lost_total;

endmodule
